[design/rfae_pkg.sv]
// Shared types, constants and helpers for the register file / ALU executor.
// No dependencies; every other design file refers to this package by scope.
package rfae_pkg;

  localparam int NUM_REGS   = 26;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(NUM_REGS);
  localparam int IDX_W      = 5;
  localparam int OPC_W      = 4;
  localparam int IO_W       = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD     = 4'd0,
    OP_OUTPUT   = 4'd1,
    OP_MOVE     = 4'd2,
    OP_EXCHANGE = 4'd3,
    OP_ADD      = 4'd4,
    OP_SUB      = 4'd5,
    OP_MUL      = 4'd6,
    OP_DIV      = 4'd7,
    OP_MOD      = 4'd8,
    OP_AND      = 4'd9,
    OP_OR       = 4'd10,
    OP_XOR      = 4'd11
  } op_t;

  localparam logic ST_VALUE    = 1'b0;
  localparam logic ST_DIV_ZERO = 1'b1;

  typedef enum logic {
    WA_DEST,
    WA_SRC_A
  } wr_addr_t;

  typedef enum logic [2:0] {
    WD_IMM,
    WD_X,
    WD_Y,
    WD_ALU,
    WD_ITER
  } wr_data_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_ITER,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic     accept;
    logic     wr_en;
    wr_addr_t wr_addr;
    wr_data_t wr_data;
    logic     iter_start;
    logic     out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic y_zero;
    logic iter_done;
    logic out_busy;
  } sts_t;

  function automatic logic in_range(idx_t idx);
    return 32'(idx) < 32'(NUM_REGS);
  endfunction

  function automatic addr_t to_addr(idx_t idx);
    return addr_t'(idx);
  endfunction

  // two-source ALU ops (add .. xor) pick operands by the three_operand flag
  function automatic logic is_alu(logic [OPC_W-1:0] opc);
    return (opc >= OP_ADD) && (opc <= OP_XOR);
  endfunction

endpackage

[design/rfae_req_if.sv]
// Request channel: one decoded instruction per handshake.
// Depends on rfae_pkg for field widths.
interface rfae_req_if;
  logic                            valid;
  logic                            ready;
  logic [rfae_pkg::OPC_W-1:0]      operation;
  logic [rfae_pkg::IDX_W-1:0]      dest_reg;
  logic [rfae_pkg::IDX_W-1:0]      src_a_reg;
  logic [rfae_pkg::IDX_W-1:0]      src_b_reg;
  logic                            three_operand;
  logic signed [rfae_pkg::IO_W-1:0] load_value;

  modport source (
    output valid, operation, dest_reg, src_a_reg, src_b_reg, three_operand, load_value,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_reg, src_a_reg, src_b_reg, three_operand, load_value,
    output ready
  );
endinterface

[design/rfae_rsp_if.sv]
// Result channel: register value or divide-by-zero status.
// Depends on rfae_pkg for field widths.
interface rfae_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [rfae_pkg::IO_W-1:0] value;
  logic                             status;

  modport source (
    output valid, value, status,
    input  ready
  );
  modport sink (
    input  valid, value, status,
    output ready
  );
endinterface

[design/rfae_iter.sv]
// Iterative unit: radix-2 shift-add multiply and restoring signed divide/modulo,
// one bit per cycle, one step per bit of DATA_WIDTH. Depends on rfae_pkg.
module rfae_iter (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rfae_pkg::op_t   op,
  input  rfae_pkg::word_t x,
  input  rfae_pkg::word_t y,
  output logic            done,
  output rfae_pkg::word_t result
);

  localparam int DW = rfae_pkg::DATA_WIDTH;
  localparam logic [rfae_pkg::CNT_W-1:0] LAST = rfae_pkg::CNT_W'(DW - 1);

  logic                        busy;
  logic [rfae_pkg::CNT_W-1:0]  cnt;
  rfae_pkg::op_t               mode;
  logic                        neg_q;
  logic                        neg_r;
  logic [DW:0]                 acc;   // product, or partial remainder
  logic [DW-1:0]               quo;   // multiplier bits, or dividend/quotient
  logic [DW-1:0]               dvs;   // multiplicand, or divisor magnitude
  logic [DW-1:0]               x_mag;
  logic [DW-1:0]               y_mag;
  logic [DW:0]                 rem_sh;
  logic [DW:0]                 diff;
  logic [DW-1:0]               mul_sum;

  assign x_mag   = x[DW-1] ? (~x + 1'b1) : x;
  assign y_mag   = y[DW-1] ? (~y + 1'b1) : y;
  assign rem_sh  = {acc[DW-1:0], quo[DW-1]};
  assign diff    = rem_sh - {1'b0, dvs};
  assign mul_sum = acc[DW-1:0] + (quo[0] ? dvs : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode  <= op;
      neg_q <= x[DW-1] ^ y[DW-1];
      neg_r <= x[DW-1];
      acc   <= '0;
      if (op == rfae_pkg::OP_MUL) begin
        quo <= x;
        dvs <= y;
      end else begin
        quo <= x_mag;
        dvs <= y_mag;
      end
    end else if (busy) begin
      if (mode == rfae_pkg::OP_MUL) begin
        acc <= {1'b0, mul_sum};
        quo <= quo >> 1;
        dvs <= dvs << 1;
      end else if (!diff[DW]) begin
        acc <= diff;
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        acc <= rem_sh;
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    priority if (mode == rfae_pkg::OP_MUL) begin
      result = acc[DW-1:0];
    end else if (mode == rfae_pkg::OP_DIV) begin
      result = neg_q ? (~quo + 1'b1) : quo;
    end else begin
      result = neg_r ? (~acc[DW-1:0] + 1'b1) : acc[DW-1:0];
    end
  end

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("iter unit not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("iter done while still busy");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == LAST |=> done)
    else $error("iter done missing after last step");
`endif

endmodule

[design/rfae_dp.sv]
// Datapath: register file with valid bits, operand registers, ALU, iterative
// unit and result register. Depends on rfae_pkg and rfae_iter.
module rfae_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  rfae_pkg::cmd_t                   cmd,
  output rfae_pkg::sts_t                   sts,
  input  logic [rfae_pkg::OPC_W-1:0]       operation,
  input  rfae_pkg::idx_t                   dest_reg,
  input  rfae_pkg::idx_t                   src_a_reg,
  input  rfae_pkg::idx_t                   src_b_reg,
  input  logic                             three_operand,
  input  logic signed [rfae_pkg::IO_W-1:0] load_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [rfae_pkg::IO_W-1:0] out_value,
  output logic                             out_status
);

  localparam int NR = rfae_pkg::NUM_REGS;

  rfae_pkg::word_t  mem [NR];
  logic [NR-1:0]    vld;

  rfae_pkg::op_t    op_q;
  rfae_pkg::idx_t   d_q;
  rfae_pkg::idx_t   sa_q;
  rfae_pkg::word_t  imm_q;
  rfae_pkg::word_t  x_q;
  rfae_pkg::word_t  y_q;

  rfae_pkg::idx_t   x_idx;
  rfae_pkg::idx_t   y_idx;
  rfae_pkg::addr_t  x_addr;
  rfae_pkg::addr_t  y_addr;
  rfae_pkg::idx_t   wr_idx;
  rfae_pkg::addr_t  wr_addr;
  rfae_pkg::word_t  wr_data;
  rfae_pkg::word_t  alu_res;
  rfae_pkg::word_t  iter_res;
  logic             iter_done;
  logic             two_src;

  assign two_src = rfae_pkg::is_alu(operation) && three_operand;
  assign x_idx   = two_src ? src_a_reg : dest_reg;
  assign y_idx   = two_src ? src_b_reg : src_a_reg;
  assign x_addr  = rfae_pkg::to_addr(x_idx);
  assign y_addr  = rfae_pkg::to_addr(y_idx);

  // request latch and registered operand reads
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= rfae_pkg::op_t'(operation);
      d_q   <= dest_reg;
      sa_q  <= src_a_reg;
      imm_q <= rfae_pkg::word_t'(load_value);
      x_q   <= (rfae_pkg::in_range(x_idx) && vld[x_addr]) ? mem[x_addr] : '0;
      y_q   <= (rfae_pkg::in_range(y_idx) && vld[y_addr]) ? mem[y_addr] : '0;
    end
  end

  assign wr_idx  = (cmd.wr_addr == rfae_pkg::WA_DEST) ? d_q : sa_q;
  assign wr_addr = rfae_pkg::to_addr(wr_idx);

  always_comb begin
    unique case (cmd.wr_data)
      rfae_pkg::WD_IMM:  wr_data = imm_q;
      rfae_pkg::WD_X:    wr_data = x_q;
      rfae_pkg::WD_Y:    wr_data = y_q;
      rfae_pkg::WD_ALU:  wr_data = alu_res;
      rfae_pkg::WD_ITER: wr_data = iter_res;
      default:           wr_data = imm_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && rfae_pkg::in_range(wr_idx)) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.wr_en && rfae_pkg::in_range(wr_idx)) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    unique case (op_q)
      rfae_pkg::OP_ADD: alu_res = x_q + y_q;
      rfae_pkg::OP_SUB: alu_res = x_q - y_q;
      rfae_pkg::OP_AND: alu_res = x_q & y_q;
      rfae_pkg::OP_OR:  alu_res = x_q | y_q;
      default:          alu_res = x_q ^ y_q;
    endcase
  end

  rfae_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.iter_start),
    .op     (op_q),
    .x      (x_q),
    .y      (y_q),
    .done   (iter_done),
    .result (iter_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (op_q == rfae_pkg::OP_OUTPUT) begin
        out_value  <= rfae_pkg::IO_W'(x_q);
        out_status <= rfae_pkg::ST_VALUE;
      end else begin
        out_value  <= '0;
        out_status <= rfae_pkg::ST_DIV_ZERO;
      end
    end
  end

  assign sts.op        = op_q;
  assign sts.y_zero    = (y_q == '0);
  assign sts.iter_done = iter_done;
  assign sts.out_busy  = out_valid && !out_ready;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result register overwritten while pending");
`endif

endmodule

[design/rfae_ctrl.sv]
// Controller: sequences accept, execute, second write of exchange, iterative
// ops and result emission. Depends on rfae_pkg.
module rfae_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output rfae_pkg::cmd_t cmd,
  input  rfae_pkg::sts_t sts
);

  rfae_pkg::state_t state;
  rfae_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfae_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.wr_addr = rfae_pkg::WA_DEST;
    cmd.wr_data = rfae_pkg::WD_IMM;
    state_next  = state;
    in_ready    = (state == rfae_pkg::S_IDLE) && !rst;
    unique case (state)
      rfae_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_next = rfae_pkg::S_EXEC;
        end
      end
      rfae_pkg::S_EXEC: begin
        state_next = rfae_pkg::S_IDLE;
        unique case (sts.op)
          rfae_pkg::OP_LOAD: begin
            cmd.wr_en = 1'b1;
          end
          rfae_pkg::OP_OUTPUT: begin
            state_next = rfae_pkg::S_EMIT;
          end
          rfae_pkg::OP_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = rfae_pkg::WD_Y;
          end
          rfae_pkg::OP_EXCHANGE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = rfae_pkg::WD_Y;
            state_next  = rfae_pkg::S_SWAP;
          end
          rfae_pkg::OP_ADD, rfae_pkg::OP_SUB, rfae_pkg::OP_AND,
          rfae_pkg::OP_OR, rfae_pkg::OP_XOR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = rfae_pkg::WD_ALU;
          end
          rfae_pkg::OP_MUL: begin
            cmd.iter_start = 1'b1;
            state_next     = rfae_pkg::S_ITER;
          end
          rfae_pkg::OP_DIV, rfae_pkg::OP_MOD: begin
            if (sts.y_zero) begin
              state_next = rfae_pkg::S_EMIT;
            end else begin
              cmd.iter_start = 1'b1;
              state_next     = rfae_pkg::S_ITER;
            end
          end
          default: ;  // unused opcodes: dropped
        endcase
      end
      rfae_pkg::S_SWAP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = rfae_pkg::WA_SRC_A;
        cmd.wr_data = rfae_pkg::WD_X;
        state_next  = rfae_pkg::S_IDLE;
      end
      rfae_pkg::S_ITER: begin
        if (sts.iter_done) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_data = rfae_pkg::WD_ITER;
          state_next  = rfae_pkg::S_IDLE;
        end
      end
      rfae_pkg::S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = rfae_pkg::S_IDLE;
        end
      end
      default: state_next = rfae_pkg::S_IDLE;
    endcase
  end

endmodule

[design/register_file_alu_executor_top.sv]
// Top level of the register file / ALU executor.
// Depends on rfae_pkg, rfae_req_if, rfae_rsp_if, rfae_ctrl and rfae_dp.
//
// Usage:
//   req : request channel (valid/ready), one decoded instruction per request:
//         operation, dest_reg, src_a_reg, src_b_reg, three_operand, load_value.
//   rsp : result channel (valid/ready), value and status. Only output
//         requests and divide/modulo by zero produce a result; every other
//         request produces none and at most updates the register file.
// Sequence, from acceptance of a request to the next possible acceptance:
//   load, move, add, sub, and, or, xor ....... execute, writing the result
//   exchange (two register file writes) ....... execute, then swap
//   output, divide/modulo by zero ............. execute, then emit once rsp is free
//   mul, div, mod ............................. execute, then iterate until done
//   The long case is the one-bit-per-cycle shift-add / restoring divide unit.
// A result sits in an output register; while it waits, requests that yield no
// result keep flowing. A request that must emit while the register is still
// full holds the controller until rsp takes the pending result.
// Reset (rst, synchronous) clears the valid bits of the register file, so all
// registers read as zero, empties the result register and idles the
// controller. The block is ready as soon as reset is released.
module register_file_alu_executor_top (
  input  logic       clk,
  input  logic       rst,
  rfae_req_if.sink   req,
  rfae_rsp_if.source rsp
);

  rfae_pkg::cmd_t cmd;
  rfae_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;
  logic signed [rfae_pkg::IO_W-1:0] out_value;
  logic           out_status;

  // sequencing only; no payload passes through the controller
  rfae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // register file, operand reads, ALU, iterative unit, result register
  rfae_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (req.operation),
    .dest_reg      (req.dest_reg),
    .src_a_reg     (req.src_a_reg),
    .src_b_reg     (req.src_b_reg),
    .three_operand (req.three_operand),
    .load_value    (req.load_value),
    .out_ready     (rsp.ready),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_status    (out_status)
  );

  assign req.ready  = in_ready;
  assign rsp.valid  = out_valid;
  assign rsp.value  = out_value;
  assign rsp.status = out_status;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for register_file_alu_executor_top: directed table, then random traffic.
// Depends on rfae_pkg, rfae_req_if, rfae_rsp_if and the design top; results are checked
// against an in-bench mirror of the register file.
module testbench;
  import rfae_pkg::*;

  localparam int CLK_HALF_NS     = 6;
  localparam int RESET_CYCLES    = 4;
  localparam int RAND_ITEMS      = 950;
  localparam int MAX_GAP         = 16;
  localparam int RSP_HOLD_CYCLES = 300;  // long receiver hold-off for back-pressure
  localparam int FLOOD_AT        = 350;  // random item where the hold-off starts
  localparam int FLOOD_ITEMS     = 40;
  localparam int QUIESCE_AT      = 650;  // random item where the sender waits for all results
  localparam int TAIL_CYCLES     = 40;   // outlasts the longest instruction (mul, div, mod)
  localparam int TIMEOUT_NS      = 10_000_000;
  localparam int IDX_MAX         = (1 << IDX_W) - 1;

  localparam logic [OPC_W-1:0] OPC_UNUSED_FIRST = OPC_W'(OP_XOR + 1);
  localparam logic [OPC_W-1:0] OPC_UNUSED_LAST  = '1;

  localparam logic [IO_W-1:0] WORD_MAX = {1'b0, {(IO_W-1){1'b1}}};
  localparam logic [IO_W-1:0] WORD_MIN = {1'b1, {(IO_W-1){1'b0}}};
  localparam logic [IO_W-1:0] WORD_M1  = '1;

  // One decoded instruction as it goes onto the request channel.
  typedef struct packed {
    logic [OPC_W-1:0] opc;
    idx_t             dest;
    idx_t             src_a;
    idx_t             src_b;
    logic             three;
    logic [IO_W-1:0]  imm;
  } instr_t;

  typedef struct packed {
    logic [IO_W-1:0] value;
    logic            status;
  } result_t;

  // Directed stimulus row; 'typed' rows carry their own expected result.
  typedef struct packed {
    instr_t  instr;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rfae_req_if req_ch ();
  rfae_rsp_if rsp_ch ();

  register_file_alu_executor_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Mirror of the architectural register file and the results still owed by the block.
  logic [DATA_WIDTH-1:0] arch_regs [NUM_REGS];
  result_t               pending_results [$];
  dir_row_t              dir_rows [$];

  int mismatch_count = 0;
  int req_mode       = 0;  // idling style of the sender, see draw_gap
  bit rsp_hold_req   = 0;  // asks the result sink for one long hold-off

  initial begin : clock_gen
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Gap styles: 0 = uniform random gaps, 1 = back-to-back, 2 = mostly back-to-back with odd gaps.
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return $urandom_range(0, MAX_GAP);
      1:       return 0;
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  // Indices past the last register read as zero and drop writes.
  function automatic logic [DATA_WIDTH-1:0] reg_read(input idx_t idx);
    if (idx < NUM_REGS) return arch_regs[idx];
    return '0;
  endfunction

  task automatic reg_write(input idx_t idx, input logic [DATA_WIDTH-1:0] v);
    if (idx < NUM_REGS) arch_regs[idx] = v;
  endtask

  // Executes one instruction on the mirror; 'emits' tells whether the block owes a result.
  task automatic predict_instr(input instr_t it, output bit emits, output result_t res);
    logic [DATA_WIDTH-1:0] x, y, r;
    longint                xl, yl;
    bit                    writes;
    emits      = 0;
    writes     = 0;
    res.value  = '0;
    res.status = ST_VALUE;
    r          = '0;
    case (it.opc)
      OP_LOAD: begin
        r      = it.imm;
        writes = 1;
      end
      OP_OUTPUT: begin
        emits     = 1;
        res.value = reg_read(it.dest);
      end
      OP_MOVE: begin
        r      = reg_read(it.src_a);
        writes = 1;
      end
      OP_EXCHANGE: begin
        x = reg_read(it.dest);
        y = reg_read(it.src_a);
        reg_write(it.dest, y);
        reg_write(it.src_a, x);
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR: begin
        if (it.three) begin
          x = reg_read(it.src_a);
          y = reg_read(it.src_b);
        end else begin
          x = reg_read(it.dest);
          y = reg_read(it.src_a);
        end
        if ((it.opc == OP_DIV || it.opc == OP_MOD) && y == '0) begin
          // zero divisor: destination kept, error result
          emits      = 1;
          res.status = ST_DIV_ZERO;
        end else begin
          // 64-bit signed math keeps min / -1 from overflowing; truncation wraps it
          xl = longint'($signed(x));
          yl = longint'($signed(y));
          case (it.opc)
            OP_ADD:  r = x + y;
            OP_SUB:  r = x - y;
            OP_MUL:  r = x * y;
            OP_DIV:  r = DATA_WIDTH'(xl / yl);
            OP_MOD:  r = DATA_WIDTH'(xl % yl);
            OP_AND:  r = x & y;
            OP_OR:   r = x | y;
            default: r = x ^ y;
          endcase
          writes = 1;
        end
      end
      default: ;  // unused codes are ignored
    endcase
    if (writes) reg_write(it.dest, r);
  endtask

  task automatic add_row(input logic [OPC_W-1:0] opc, input idx_t d, input idx_t a,
                         input idx_t b, input logic three, input logic [IO_W-1:0] imm,
                         input logic typed, input logic [IO_W-1:0] ev, input logic es);
    dir_row_t row;
    row.instr = '{opc: opc, dest: d, src_a: a, src_b: b, three: three, imm: imm};
    row.typed = typed;
    row.want  = '{value: ev, status: es};
    dir_rows.push_back(row);
  endtask

  function automatic idx_t rand_index();
    if ($urandom_range(0, 15) == 0) return idx_t'($urandom_range(NUM_REGS, IDX_MAX));
    return idx_t'($urandom_range(0, NUM_REGS - 1));
  endfunction

  // Extremes, zeros and small numbers dominate so that wraps, zero divisors
  // and sign cases come up often.
  function automatic logic [IO_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WORD_MAX;
      2:       return WORD_MIN;
      3:       return WORD_M1;
      4:       return IO_W'(1);
      5, 6:    return IO_W'($urandom_range(0, 20)) - IO_W'(10);
      default: return $urandom;
    endcase
  endfunction

  // flood biases toward output instructions to fill the result path.
  function automatic instr_t rand_instr(input bit flood);
    instr_t it;
    int     pick;
    pick     = (flood && $urandom_range(0, 3) != 0) ? 20 : $urandom_range(0, 99);
    it.dest  = rand_index();
    it.src_a = rand_index();
    it.src_b = rand_index();
    it.three = 1'($urandom_range(0, 1));
    it.imm   = rand_value();
    if (pick < 18)      it.opc = OP_LOAD;
    else if (pick < 33) it.opc = OP_OUTPUT;
    else if (pick < 37) it.opc = OP_MOVE;
    else if (pick < 41) it.opc = OP_EXCHANGE;
    else if (pick < 98) it.opc = OPC_W'(OP_ADD + $urandom_range(0, OP_XOR - OP_ADD));
    else                it.opc = OPC_W'($urandom_range(OPC_UNUSED_FIRST, OPC_UNUSED_LAST));
    return it;
  endfunction

  // Offers one request after a drawn gap and returns at the edge where it is taken.
  // valid stays high across back-to-back requests; it only drops when a gap follows.
  task automatic offer_instr(input instr_t it);
    int gap;
    gap = draw_gap(req_mode);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.operation     <= it.opc;
    req_ch.dest_reg      <= it.dest;
    req_ch.src_a_reg     <= it.src_a;
    req_ch.src_b_reg     <= it.src_b;
    req_ch.three_operand <= it.three;
    req_ch.load_value    <= it.imm;
    req_ch.valid         <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Sender: reset, directed table, random traffic, then drain and verdict.
  initial begin : instr_source
    instr_t  it;
    result_t res;
    bit      emits;
    int      useful;
    int      n;

    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_LOAD;
    req_ch.dest_reg      <= '0;
    req_ch.src_a_reg     <= '0;
    req_ch.src_b_reg     <= '0;
    req_ch.three_operand <= 1'b0;
    req_ch.load_value    <= '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Typed rows: reset state, extremes, min / -1, zero divisors,
    // out-of-range index. The rest rely on the predictor.
    //       opc          d   a   b   3  imm        typed ev        status
    add_row(OP_OUTPUT,    0,  0,  0,  0, '0,        1,    '0,       ST_VALUE);
    add_row(OP_LOAD,      0,  0,  0,  0, WORD_MAX,  0,    '0,       ST_VALUE);
    add_row(OP_OUTPUT,    0,  0,  0,  0, '0,        1,    WORD_MAX, ST_VALUE);
    add_row(OP_LOAD,      1, 31, 31,  1, WORD_MIN,  0,    '0,       ST_VALUE);
    add_row(OP_LOAD,      2,  0,  0,  0, WORD_M1,   0,    '0,       ST_VALUE);
    add_row(OP_DIV,       3,  1,  2,  1, '0,        0,    '0,       ST_VALUE);
    add_row(OP_MOD,       4,  1,  2,  1, '0,        0,    '0,       ST_VALUE);
    add_row(OP_OUTPUT,    3,  0,  0,  0, '0,        1,    WORD_MIN, ST_VALUE);
    add_row(OP_OUTPUT,    4,  0,  0,  0, '0,        1,    '0,       ST_VALUE);
    add_row(OP_DIV,       0,  5,  0,  0, '0,        1,    '0,       ST_DIV_ZERO);
    add_row(OP_MOD,       6,  0,  5,  1, '0,        1,    '0,       ST_DIV_ZERO);
    add_row(OP_OUTPUT,    0,  0,  0,  0, '0,        1,    WORD_MAX, ST_VALUE);
    add_row(OP_LOAD,     31, 31, 31,  1, WORD_M1,   0,    '0,       ST_VALUE);
    add_row(OP_OUTPUT,   31, 31, 31,  1, WORD_M1,   1,    '0,       ST_VALUE);
    add_row(OP_ADD,       0,  0,  0,  0, '0,        0,    '0,       ST_VALUE);
    add_row(OP_MUL,       7,  1,  2,  1, '0,        0,    '0,       ST_VALUE);
    add_row(OP_SUB,       8,  1,  0,  1, '0,        0,    '0,       ST_VALUE);
    add_row(OP_MOVE,      9,  1,  0,  0, '0,        0,    '0,       ST_VALUE);
    add_row(OP_EXCHANGE,  9,  2,  0,  0, '0,        0,    '0,       ST_VALUE);
    add_row(OP_AND,      10,  0,  2,  1, '0,        0,    '0,       ST_VALUE);
    add_row(OP_OR,       11,  0,  1,  1, '0,        0,    '0,       ST_VALUE);
    add_row(OP_XOR,      12,  1,  2,  1, '0,        0,    '0,       ST_VALUE);
    add_row(OPC_UNUSED_LAST, 0, 0, 0, 0, WORD_M1,   0,    '0,       ST_VALUE);
    add_row(OP_OUTPUT,    9,  0,  0,  0, '0,        0,    '0,       ST_VALUE);
    add_row(OP_OUTPUT,    2,  0,  0,  0, '0,        0,    '0,       ST_VALUE);
    add_row(OP_OUTPUT,    8,  0,  0,  0, '0,        0,    '0,       ST_VALUE);

    foreach (dir_rows[i]) begin
      offer_instr(dir_rows[i].instr);
      // the mirror always executes so later rows see the right state
      predict_instr(dir_rows[i].instr, emits, res);
      if (dir_rows[i].typed) pending_results.push_back(dir_rows[i].want);
      else if (emits) pending_results.push_back(res);
    end

    // Random traffic. Ignored opcodes do not count toward the item total.
    useful = 0;
    n      = 0;
    while (useful < RAND_ITEMS) begin
      if (n % 64 == 0) req_mode = $urandom_range(0, 2);
      if (useful == FLOOD_AT && !rsp_hold_req) begin
        // receiver goes quiet while requests keep coming back-to-back
        rsp_hold_req = 1;
        req_mode     = 1;
      end
      if (useful == QUIESCE_AT) begin
        // sender pauses until every owed result has been taken
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      it = rand_instr(useful >= FLOOD_AT && useful < FLOOD_AT + FLOOD_ITEMS);
      offer_instr(it);
      predict_instr(it, emits, res);
      if (emits) pending_results.push_back(res);
      if (it.opc <= OP_XOR) useful++;
      n++;
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // stray results would show up in this window
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("register_file_alu_executor_top regression: pass");
    end else begin
      $display("register_file_alu_executor_top regression: fail");
    end
    $finish;
  end

  // Result sink: random stalls per result, one long hold-off on request,
  // and a field-by-field compare against the oldest owed result.
  initial begin : result_sink
    result_t want;
    int      stall;
    int      mode;
    rsp_ch.ready <= 1'b0;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) mode = $urandom_range(0, 2);
      stall = draw_gap(mode);
      if (rsp_hold_req) begin
        stall        = RSP_HOLD_CYCLES;
        rsp_hold_req = 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: result with none owed: value %0d status %0b",
                 $time, rsp_ch.value, rsp_ch.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.value !== want.value) begin
          $display("%0t: value mismatch: expected %0d actual %0d",
                   $time, $signed(want.value), rsp_ch.value);
          mismatch_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status mismatch: expected %0b actual %0b",
                   $time, want.status, rsp_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("register_file_alu_executor_top regression: fail");
    $finish;
  end

endmodule
